>>> hw/rtl/json_string_unescape_assert.svh
// Assertion macros for the JSON string unescape block.
// Included by the modules that check their own logic; no other dependencies.
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH
`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge outside reset.
`define JSU_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// Checks that a condition is followed by a consequence in the next cycle.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define JSU_ASSERT_ALWAYS(lbl, expr, msg)
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/jsu_pkg.sv
// Shared types and constants of the JSON string unescape block.
// Used by every module of the block; depends on nothing.
package jsu_pkg;

   // Result kinds.
   localparam logic [2:0] KIND_DATA    = 3'd0;
   localparam logic [2:0] KIND_DONE    = 3'd1;
   localparam logic [2:0] KIND_NOQUOTE = 3'd2;
   localparam logic [2:0] KIND_BADESC  = 3'd3;
   localparam logic [2:0] KIND_BADHEX  = 3'd4;
   localparam logic [2:0] KIND_FULL    = 3'd5;
   localparam logic [2:0] KIND_UNTERM  = 3'd6;

   // Capacity after reset.
   localparam logic [15:0] CAPACITY_RESET = 16'd256;

   // One group of results caused by a single request.
   typedef struct packed {
      logic [2:0]       kind;
      logic [1:0]       cnt;     // number of results, 1 to 3
      logic [2:0][7:0]  data;    // data[0] goes out first
   } entry_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

>>> hw/rtl/jsu_req_if.sv
// Request channel of the JSON string unescape block: one text byte per request.
// Standalone; no dependencies.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

>>> hw/rtl/jsu_rsp_if.sv
// Result channel of the JSON string unescape block: one decoded byte or status.
// Standalone; no dependencies.
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] out_kind;
   logic       out_last;

   modport source (output valid, output out_byte, output out_kind, output out_last,
                   input ready);
   modport sink (input valid, input out_byte, input out_kind, input out_last,
                 output ready);
endinterface

>>> hw/rtl/jsu_front.sv
// Front end: accepts text bytes, runs the escape parser and builds result groups.
// Depends on jsu_pkg and jsu_req_if.
module jsu_front (
   input  logic                     clock,
   input  logic                     reset,
   jsu_req_if.sink                  req,
   input  logic                     csr_wr_en,
   input  logic [15:0]              csr_wr_data,
   input  jsu_pkg::fifo_status_type status,
   output logic                     push,
   output jsu_pkg::entry_type       push_entry
);

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_STR  = 3'd1;
   localparam logic [2:0] MODE_ESC  = 3'd2;
   localparam logic [2:0] MODE_HEX  = 3'd3;
   localparam logic [2:0] MODE_SKIP = 3'd4;

   logic [2:0]  mode_ff, mode_in;
   logic [1:0]  hex_seen_ff, hex_seen_in;
   logic [15:0] code_ff, code_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] cap_ff;

   logic        accept;
   logic [7:0]  b;
   logic [2:0]  term_mode;
   logic        do_char;
   logic [7:0]  ch;
   logic        hex_ok;
   logic [3:0]  hex_v;
   logic [15:0] cp;
   logic [1:0]  need;
   logic        fits;

   // Value of an ASCII hex digit, either case; valid flags a digit.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   assign req.ready = !status.full;
   assign accept    = req.valid && req.ready;
   assign b         = req.in_byte;
   assign term_mode = (b == 8'h00) ? MODE_IDLE : MODE_SKIP;
   assign {hex_ok, hex_v} = hex_decode(b);
   assign cp        = {code_ff[11:0], hex_v};

   // Number of bytes the pending output group needs.
   always_comb begin
      if (mode_ff == MODE_HEX) begin
         if (cp <= 16'h007F) begin
            need = 2'd1;
         end else if (cp <= 16'h07FF) begin
            need = 2'd2;
         end else begin
            need = 2'd3;
         end
      end else begin
         need = 2'd1;
      end
   end

   // A group is kept only while there is room left for the terminator.
   assign fits = ({1'b0, count_ff} + {15'd0, need}) < {1'b0, cap_ff};

   // Parser step for one accepted request.
   always_comb begin
      mode_in     = mode_ff;
      hex_seen_in = hex_seen_ff;
      code_in     = code_ff;
      count_in    = count_ff;
      push        = 1'b0;
      push_entry  = '0;
      do_char     = 1'b0;
      ch          = b;
      if (accept) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (b == 8'h22) begin
                  mode_in  = MODE_STR;
                  count_in = 16'd0;
               end else begin
                  push            = 1'b1;
                  push_entry.kind = jsu_pkg::KIND_NOQUOTE;
                  push_entry.cnt  = 2'd1;
                  mode_in         = term_mode;
               end
            end
            MODE_STR: begin
               if (b == 8'h00) begin
                  push            = 1'b1;
                  push_entry.kind = jsu_pkg::KIND_UNTERM;
                  push_entry.cnt  = 2'd1;
                  mode_in         = MODE_IDLE;
               end else if (b == 8'h22) begin
                  push            = 1'b1;
                  push_entry.kind = jsu_pkg::KIND_DONE;
                  push_entry.cnt  = 2'd1;
                  mode_in         = MODE_SKIP;
               end else if (b == 8'h5C) begin
                  mode_in = MODE_ESC;
               end else begin
                  do_char = 1'b1;
               end
            end
            MODE_ESC: begin
               do_char = 1'b1;
               mode_in = MODE_STR;
               case (b)
                  8'h22, 8'h5C, 8'h2F: ch = b;
                  8'h62:               ch = 8'h08;
                  8'h66:               ch = 8'h0C;
                  8'h6E:               ch = 8'h0A;
                  8'h72:               ch = 8'h0D;
                  8'h74:               ch = 8'h09;
                  8'h75: begin
                     do_char     = 1'b0;
                     mode_in     = MODE_HEX;
                     hex_seen_in = 2'd0;
                     code_in     = 16'd0;
                  end
                  default: begin
                     do_char         = 1'b0;
                     push            = 1'b1;
                     push_entry.kind = jsu_pkg::KIND_BADESC;
                     push_entry.cnt  = 2'd1;
                     mode_in         = term_mode;
                  end
               endcase
            end
            MODE_HEX: begin
               if (!hex_ok) begin
                  push            = 1'b1;
                  push_entry.kind = jsu_pkg::KIND_BADHEX;
                  push_entry.cnt  = 2'd1;
                  mode_in         = term_mode;
               end else if (hex_seen_ff != 2'd3) begin
                  code_in     = cp;
                  hex_seen_in = hex_seen_ff + 2'd1;
               end else begin
                  code_in     = cp;
                  hex_seen_in = 2'd0;
                  push        = 1'b1;
                  push_entry.cnt = 2'd1;
                  if (!fits) begin
                     push_entry.kind = jsu_pkg::KIND_FULL;
                     mode_in         = term_mode;
                  end else begin
                     // UTF-8 encoding of the 16-bit code point.
                     push_entry.kind = jsu_pkg::KIND_DATA;
                     push_entry.cnt  = need;
                     count_in        = count_ff + {14'd0, need};
                     mode_in         = MODE_STR;
                     case (need)
                        2'd1: push_entry.data[0] = cp[7:0];
                        2'd2: begin
                           push_entry.data[0] = {3'b110, cp[10:6]};
                           push_entry.data[1] = {2'b10, cp[5:0]};
                        end
                        default: begin
                           push_entry.data[0] = {4'b1110, cp[15:12]};
                           push_entry.data[1] = {2'b10, cp[11:6]};
                           push_entry.data[2] = {2'b10, cp[5:0]};
                        end
                     endcase
                  end
               end
            end
            default: begin
               mode_in = term_mode;
            end
         endcase

         // A single plain or simply escaped character.
         if (do_char) begin
            push           = 1'b1;
            push_entry.cnt = 2'd1;
            if (fits) begin
               push_entry.kind    = jsu_pkg::KIND_DATA;
               push_entry.data[0] = ch;
               count_in           = count_ff + 16'd1;
            end else begin
               push_entry.kind = jsu_pkg::KIND_FULL;
               mode_in         = term_mode;
            end
         end
      end
   end

   // Parser state and capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         hex_seen_ff <= 2'd0;
         code_ff     <= 16'd0;
         count_ff    <= 16'd0;
         cap_ff      <= jsu_pkg::CAPACITY_RESET;
      end else begin
         mode_ff     <= mode_in;
         hex_seen_ff <= hex_seen_in;
         code_ff     <= code_in;
         count_ff    <= count_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

endmodule

>>> hw/rtl/jsu_fifo.sv
// Short queue of result groups between the front end and the back end.
// Depends on jsu_pkg and the assertion macro header.
`include "json_string_unescape_assert.svh"
module jsu_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  jsu_pkg::entry_type       push_entry,
   input  logic                     pop,
   output jsu_pkg::entry_type       head,
   output jsu_pkg::fifo_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   jsu_pkg::entry_type entries [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff, count_in;

   assign status.full  = (count_ff == DEPTH_CNT);
   assign status.empty = (count_ff == '0);
   assign head         = entries[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_entry;
      end
   end

   `JSU_ASSERT_ALWAYS(a_no_push_full, !(push && status.full), "push into full queue")
   `JSU_ASSERT_ALWAYS(a_no_pop_empty, !(pop && status.empty), "pop from empty queue")
   `JSU_ASSERT_ALWAYS(a_count_range, count_ff <= DEPTH_CNT, "queue count beyond depth")

endmodule

>>> hw/rtl/jsu_back.sv
// Back end: sends the bytes of each queued group one result at a time.
// Depends on jsu_pkg, jsu_rsp_if and the assertion macro header.
`include "json_string_unescape_assert.svh"
module jsu_back (
   input  logic                     clock,
   input  logic                     reset,
   input  jsu_pkg::entry_type       head,
   input  jsu_pkg::fifo_status_type status,
   output logic                     pop,
   jsu_rsp_if.source                rsp
);

   logic [1:0] sub_ff, sub_in;
   logic       last;
   logic       take;

   assign last      = (sub_ff == head.cnt - 2'd1);
   assign take      = rsp.valid && rsp.ready;
   assign pop       = take && last;
   assign rsp.valid = !status.empty;
   assign rsp.out_kind = head.kind;
   assign rsp.out_last = last;

   // Select the current byte of the group.
   always_comb begin
      case (sub_ff)
         2'd0:    rsp.out_byte = head.data[0];
         2'd1:    rsp.out_byte = head.data[1];
         default: rsp.out_byte = head.data[2];
      endcase
   end

   // Position within the group.
   always_comb begin
      sub_in = sub_ff;
      if (take) begin
         sub_in = last ? 2'd0 : sub_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 2'd0;
      end else begin
         sub_ff <= sub_in;
      end
   end

   `JSU_ASSERT_ALWAYS(a_sub_in_group, !rsp.valid || (sub_ff < head.cnt), "index past group")
   `JSU_ASSERT_NEXT(a_sub_hold, rsp.valid && !rsp.ready, $stable(sub_ff), "index moved in stall")
   `JSU_ASSERT_ALWAYS(a_status_last, !rsp.valid || rsp.out_kind == jsu_pkg::KIND_DATA || rsp.out_last, "status result not last")

endmodule

>>> hw/rtl/json_string_unescape.sv
// JSON string unescape: takes a quoted JSON string one text byte per request (byte 0
// ends the text) and returns the decoded bytes, UTF-8 encoded for \u escapes, followed by
// a done or error result; bytes after a done or error are dropped up to the end of text.
// A request is accepted every cycle while the result queue (FIFO_DEPTH groups) has room;
// its results are written into the queue and leave it one per cycle while rsp_if is ready,
// so a \u escape that yields two or three bytes holds the result port for each of its bytes
// and sets the sustained rate when such escapes are frequent. The capacity register, which
// includes the terminator, is written through csr_wr_en and csr_wr_data and resets to 256.
module json_string_unescape #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   jsu_req_if.sink     req_if,
   jsu_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   jsu_pkg::fifo_status_type status;
   jsu_pkg::entry_type       push_entry;
   jsu_pkg::entry_type       head;
   logic                     push;
   logic                     pop;

   // Parser and capacity check.
   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Queue of result groups.
   jsu_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   // Result sequencing.
   jsu_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .status (status),
      .pop    (pop),
      .rsp    (rsp_if)
   );

endmodule
